### design/dpq_pkg.sv
// Package for the deduplicating priority queue: field widths, command and
// cell-operation codes, slot entry, cell control and neighbor link structs.
// No dependencies.
package dpq_pkg;

  localparam int ID_W   = 16;
  localparam int PRI_W  = 2;
  localparam int TIME_W = 48;
  localparam int OCC_W  = 5;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_SWEEP = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // what every cell does in a cycle
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_MARK   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_INSERT = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WORK = 1'b1
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRI_W-1:0]  pri;
    logic [TIME_W-1:0] exp;
  } entry_t;

  // broadcast from controller to all cells
  typedef struct packed {
    op_t               op;
    cmd_t              cmd;
    logic [ID_W-1:0]   id;
    logic [PRI_W-1:0]  pri;
    logic [TIME_W-1:0] exp;
    logic [TIME_W-1:0] now;
  } ctl_t;

  // what a cell shows its neighbors
  typedef struct packed {
    entry_t entry;
    logic   valid;
    logic   kill;
    logic   cond;
    logic   pre;
  } link_t;

  // chain summary back to the controller
  typedef struct packed {
    logic   any_kill;
    logic   ins_ok;
    logic   head_valid;
    entry_t head;
  } sts_t;

endpackage

### design/dpq_channels.sv
// Valid/ready channel interfaces for the command and result words.
// Depends on dpq_pkg.
interface dpq_in_if;
  import dpq_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [ID_W-1:0]   item_id;
  logic [PRI_W-1:0]  item_priority;
  logic [TIME_W-1:0] expire_at_ms;
  logic [TIME_W-1:0] now_ms;

  modport source(output valid, cmd, item_id, item_priority, expire_at_ms, now_ms,
                 input ready);
  modport sink(input valid, cmd, item_id, item_priority, expire_at_ms, now_ms,
               output ready);
endinterface

interface dpq_out_if;
  import dpq_pkg::*;
  logic              valid;
  logic              ready;
  logic              accepted;
  logic              item_valid;
  logic [ID_W-1:0]   out_id;
  logic [PRI_W-1:0]  out_priority;
  logic [TIME_W-1:0] out_expire_at_ms;
  logic [OCC_W-1:0]  occupancy;

  modport source(output valid, accepted, item_valid, out_id, out_priority,
                 out_expire_at_ms, occupancy, input ready);
  modport sink(input valid, accepted, item_valid, out_id, out_priority,
               out_expire_at_ms, occupancy, output ready);
endinterface

### design/dedup_priority_queue.sv
// Deduplicating bounded priority queue built as a row of slot cells.
// Push marks any entry with the same id, pop marks the head, sweep marks expired
// entries; the cell row then drops one marked slot per cycle, and last a push
// inserts its entry at its priority place and the result word is written.
// Result word is registered; a new command is taken while it waits.
// Synchronous active-low reset empties the queue; slot contents are not cleared.
module dedup_priority_queue #(
  parameter int CAPACITY        = 16,
  parameter int ID_BITS         = 16,
  parameter int PRIORITY_LEVELS = 4
) (
  input logic       clk,
  input logic       rst_n,
  dpq_in_if.sink    in_ch,
  dpq_out_if.source out_ch
);
  import dpq_pkg::*;

  ctl_t                ctl;
  sts_t                sts;
  link_t               lnk     [CAPACITY];
  link_t               left_l  [CAPACITY];
  link_t               right_l [CAPACITY];
  logic [CAPACITY-1:0] vld;
  logic [CAPACITY-1:0] order_bad;

  dpq_ctrl #(
    .CAPACITY        (CAPACITY),
    .ID_BITS         (ID_BITS),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .sts    (sts),
    .ctl    (ctl)
  );

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    if (k == 0) begin : g_first
      // head sees a valid, never-lower neighbor with no marks before it
      assign left_l[k] = '{entry: '0, valid: 1'b1, kill: 1'b0, cond: 1'b0, pre: 1'b0};
      assign order_bad[k] = 1'b0;
    end else begin : g_mid
      assign left_l[k] = lnk[k-1];
      assign order_bad[k] = vld[k] && (lnk[k].entry.pri > lnk[k-1].entry.pri);
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_l[k] = '0;
    end else begin : g_inner
      assign right_l[k] = lnk[k+1];
    end

    dpq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .is_head   (k == 0),
      .left_lnk  (left_l[k]),
      .right_lnk (right_l[k]),
      .lnk       (lnk[k])
    );

    assign vld[k] = lnk[k].valid;
  end

  assign sts.any_kill   = lnk[CAPACITY-1].pre;
  assign sts.ins_ok     = lnk[CAPACITY-1].cond;
  assign sts.head_valid = lnk[0].valid;
  assign sts.head       = lnk[0].entry;

  a_packed_front: assert property (@(posedge clk) disable iff (!rst_n)
    ((vld + CAPACITY'(1)) & vld) == '0)
    else $error("occupied slots not contiguous from the head");

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    order_bad == '0)
    else $error("slot priorities out of order");

  a_remove_one: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.op == OP_REMOVE |=> $countones(vld) == $countones($past(vld)) - 1)
    else $error("remove step did not drop exactly one slot");

endmodule

### design/dpq_cell.sv
// One queue slot: holds an entry, its valid bit and a pending-removal mark,
// and shifts toward either neighbor on remove/insert. Depends on dpq_pkg.
module dpq_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  dpq_pkg::ctl_t  ctl,
  input  logic           is_head,
  input  dpq_pkg::link_t left_lnk,
  input  dpq_pkg::link_t right_lnk,
  output dpq_pkg::link_t lnk
);
  import dpq_pkg::*;

  entry_t entry_r, entry_nxt;
  logic   valid_r, valid_nxt;
  logic   kill_r, kill_nxt;
  logic   cond;
  logic   pre;
  logic   mark_kill;

  // insertion point: empty slot or strictly lower priority than the new entry
  assign cond = !valid_r || (ctl.pri > entry_r.pri);
  // set at and after the first marked slot
  assign pre  = left_lnk.pre || (valid_r && kill_r);

  assign lnk.entry = entry_r;
  assign lnk.valid = valid_r;
  assign lnk.kill  = kill_r;
  assign lnk.cond  = cond;
  assign lnk.pre   = pre;

  always_comb begin
    unique case (ctl.cmd)
      CMD_PUSH:  mark_kill = valid_r && (ctl.id != '0) && (ctl.id == entry_r.id);
      CMD_POP:   mark_kill = valid_r && is_head;
      CMD_SWEEP: mark_kill = valid_r && (entry_r.exp != '0) && (ctl.now >= entry_r.exp);
      CMD_NOP:   mark_kill = 1'b0;
    endcase
  end

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    kill_nxt  = kill_r;
    unique case (ctl.op)
      OP_HOLD: begin
      end
      OP_MARK: begin
        kill_nxt = mark_kill;
      end
      OP_REMOVE: begin
        if (pre) begin
          entry_nxt = right_lnk.entry;
          valid_nxt = right_lnk.valid;
          kill_nxt  = right_lnk.kill;
        end
      end
      OP_INSERT: begin
        kill_nxt = 1'b0;
        if (cond) begin
          if (left_lnk.cond) begin
            entry_nxt = left_lnk.entry;
            valid_nxt = left_lnk.valid;
          end else begin
            entry_nxt = '{id: ctl.id, pri: ctl.pri, exp: ctl.exp};
            valid_nxt = 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      kill_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      kill_r  <= kill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

### design/dpq_ctrl.sv
// Command sequencer: takes command words, drives the cell row, keeps the
// fill count and the registered result word. Depends on dpq_pkg, dpq_channels.
module dpq_ctrl #(
  parameter int CAPACITY        = 16,
  parameter int ID_BITS         = 16,
  parameter int PRIORITY_LEVELS = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  dpq_in_if.sink        in_ch,
  dpq_out_if.source     out_ch,
  input  dpq_pkg::sts_t sts,
  output dpq_pkg::ctl_t ctl
);
  import dpq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [ID_W-1:0] ID_MASK =
    (ID_BITS >= ID_W) ? {ID_W{1'b1}} : ID_W'((64'd1 << ID_BITS) - 64'd1);
  localparam int PRI_MAX = PRIORITY_LEVELS - 1;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r;
  logic [ID_W-1:0]   id_r;
  logic [PRI_W-1:0]  pri_r;
  logic [TIME_W-1:0] exp_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              pop_valid_r;
  entry_t            pop_entry_r;

  logic              out_valid_r;
  logic              acc_r;
  logic              ival_r;
  entry_t            oent_r;
  logic [OCC_W-1:0]  occ_r;

  logic              accept;
  logic              out_free;
  logic              finish;
  logic [ID_W-1:0]   id_in;
  logic [PRI_W-1:0]  pri_in;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign id_in    = in_ch.item_id & ID_MASK;

  always_comb begin
    if (int'(in_ch.item_priority) > PRI_MAX) begin
      pri_in = PRI_W'(PRI_MAX);
    end else begin
      pri_in = in_ch.item_priority;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_WORK;
      end
      ST_WORK: begin
        if (!sts.any_kill && out_free) state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready = 1'b0;
    finish      = 1'b0;
    ctl.op      = OP_HOLD;
    ctl.cmd     = cmd_r;
    ctl.id      = id_r;
    ctl.pri     = pri_r;
    ctl.exp     = exp_r;
    ctl.now     = in_ch.now_ms;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        ctl.cmd     = cmd_t'(in_ch.cmd);
        ctl.id      = id_in;
        ctl.pri     = pri_in;
        ctl.exp     = in_ch.expire_at_ms;
        if (accept) ctl.op = OP_MARK;
      end
      ST_WORK: begin
        // one marked slot leaves per cycle, then the insert and the result
        if (sts.any_kill) begin
          ctl.op = OP_REMOVE;
        end else if (out_free) begin
          finish = 1'b1;
          if (cmd_r == CMD_PUSH && sts.ins_ok) ctl.op = OP_INSERT;
        end
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.op == OP_REMOVE) begin
      count_nxt = count_r - CNT_W'(1);
    end else if (ctl.op == OP_INSERT && count_r != CAP_CNT) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r       <= cmd_t'(in_ch.cmd);
      id_r        <= id_in;
      pri_r       <= pri_in;
      exp_r       <= in_ch.expire_at_ms;
      pop_valid_r <= (cmd_t'(in_ch.cmd) == CMD_POP) && sts.head_valid;
      pop_entry_r <= sts.head;
    end
    if (finish) begin
      acc_r  <= (ctl.op == OP_INSERT);
      ival_r <= pop_valid_r;
      oent_r <= pop_valid_r ? pop_entry_r : '0;
      occ_r  <= OCC_W'(count_nxt);
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.accepted         = acc_r;
  assign out_ch.item_valid       = ival_r;
  assign out_ch.out_id           = oent_r.id;
  assign out_ch.out_priority     = oent_r.pri;
  assign out_ch.out_expire_at_ms = oent_r.exp;
  assign out_ch.occupancy        = occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("fill count above capacity");

  a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(acc_r && ival_r))
    else $error("result word both stored and popped");

  a_stored_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    finish && ctl.op == OP_INSERT |=> occ_r != '0 || CNT_W > OCC_W)
    else $error("stored entry but occupancy zero");

endmodule
